// ----- design/segment_tree_range_sum_defines.svh -----
`ifndef SEGMENT_TREE_RANGE_SUM_DEFINES_SVH
`define SEGMENT_TREE_RANGE_SUM_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define STRS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define STRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/strs_pkg.sv -----
package strs_pkg;

   localparam int LEAF_COUNT_DEFAULT = 1024;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int IDX_W = 10;
   localparam int VAL_W = 32;
   localparam int SUM_W = 42;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 48;

   localparam int LEAF_INDEX_LSB  = 0;
   localparam int LEAF_VALUE_LSB  = LEAF_INDEX_LSB + IDX_W;
   localparam int RANGE_LEFT_LSB  = LEAF_VALUE_LSB + VAL_W;
   localparam int RANGE_RIGHT_LSB = RANGE_LEFT_LSB + IDX_W;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_WR,
      ST_LOAD_ADD,
      ST_Q_LO,
      ST_Q_HI,
      ST_Q_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic start;
      logic load_write;
      logic load_add;
      logic q_lo;
      logic q_hi;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic load_ok;
      logic pos_root;
      logic lo_lt_hi;
   } stat_type;

endpackage

// ----- design/strs_ctrl.sv -----
module strs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [0:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  strs_pkg::stat_type stat,
   output strs_pkg::cmd_type  cmd
);
   import strs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               if (req_tuser == MODE_QUERY) begin
                  state_in = ST_Q_LO;
               end else if (stat.load_ok) begin
                  state_in = ST_LOAD_WR;
               end
            end
         end
         ST_LOAD_WR: begin
            cmd.load_write = 1'b1;
            state_in = stat.pos_root ? ST_IDLE : ST_LOAD_ADD;
         end
         ST_LOAD_ADD: begin
            cmd.load_add = 1'b1;
            state_in = ST_LOAD_WR;
         end
         ST_Q_LO: begin
            if (stat.lo_lt_hi) begin
               cmd.q_lo = 1'b1;
               state_in = ST_Q_HI;
            end else begin
               state_in = ST_Q_DONE;
            end
         end
         ST_Q_HI: begin
            cmd.q_hi = 1'b1;
            state_in = ST_Q_LO;
         end
         ST_Q_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- design/strs_dpath.sv -----
module strs_dpath #(
   parameter int LEAF_COUNT = strs_pkg::LEAF_COUNT_DEFAULT,
   parameter int VALUE_BITS = strs_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  strs_pkg::cmd_type          cmd,
   output strs_pkg::stat_type         stat,
   input  logic [strs_pkg::IDX_W-1:0] leaf_index,
   input  logic [strs_pkg::VAL_W-1:0] leaf_value,
   input  logic [strs_pkg::IDX_W-1:0] range_left,
   input  logic [strs_pkg::IDX_W-1:0] range_right,
   output logic [strs_pkg::SUM_W-1:0] range_sum
);
   import strs_pkg::*;

   localparam int LEVELS = $clog2(LEAF_COUNT);
   localparam int NODE_W = LEVELS + 1;
   localparam int SPAN_W = LEVELS + 2;
   localparam int DEPTH  = 2 * LEAF_COUNT;

   logic [SUM_W-1:0]  mem [DEPTH];

   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0]  cur_ff, cur_in;
   logic [SPAN_W-1:0] lo_ff, lo_in;
   logic [SPAN_W-1:0] hi_ff, hi_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              acc_en_ff, acc_en_in;
   logic [SUM_W-1:0]  rdata_ff;
   logic [SUM_W-1:0]  rsp_data_ff;

   logic              we, re;
   logic [NODE_W-1:0] waddr, raddr;
   logic [SUM_W-1:0]  wdata;

   logic [SUM_W-1:0]  value_ext;
   logic [31:0]       right_sat;
   logic              empty;
   logic [SPAN_W-1:0] hi_dec;

   generate
      if (VALUE_BITS <= VAL_W) begin : g_narrow
         assign value_ext = SUM_W'(signed'(leaf_value[VALUE_BITS-1:0]));
      end else begin : g_wide
         assign value_ext = SUM_W'(leaf_value);
      end
   endgenerate

   assign right_sat = (32'(range_right) >= 32'(LEAF_COUNT)) ? 32'(LEAF_COUNT - 1)
                                                           : 32'(range_right);
   assign empty  = 32'(range_left) > right_sat;
   assign hi_dec = hi_ff - SPAN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         acc_en_ff <= 1'b0;
      end else begin
         clr_ff    <= clr_in;
         acc_en_ff <= acc_en_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      acc_ff <= acc_in;
      if (cmd.rsp_load) begin
         rsp_data_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      clr_in    = clr_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      acc_en_in = 1'b0;
      we        = 1'b0;
      re        = 1'b0;
      waddr     = pos_ff;
      wdata     = cur_ff;
      raddr     = pos_ff ^ NODE_W'(1);
      if (cmd.clear_step) begin
         we     = 1'b1;
         waddr  = clr_ff;
         wdata  = '0;
         clr_in = clr_ff + NODE_W'(1);
      end
      if (cmd.start) begin
         pos_in = NODE_W'(32'(LEAF_COUNT) + 32'(leaf_index));
         cur_in = value_ext;
         lo_in  = empty ? '0 : SPAN_W'(32'(range_left) + 32'(LEAF_COUNT));
         hi_in  = empty ? '0 : SPAN_W'(right_sat + 32'(LEAF_COUNT) + 32'd1);
      end
      if (cmd.load_write) begin
         we = 1'b1;
         re = 1'b1;
      end
      if (cmd.load_add) begin
         cur_in = cur_ff + rdata_ff;
         pos_in = pos_ff >> 1;
      end
      if (cmd.q_lo && lo_ff[0]) begin
         re        = 1'b1;
         raddr     = lo_ff[NODE_W-1:0];
         acc_en_in = 1'b1;
         lo_in     = lo_ff + SPAN_W'(1);
      end
      if (cmd.q_hi) begin
         if (hi_ff[0]) begin
            re        = 1'b1;
            raddr     = hi_dec[NODE_W-1:0];
            acc_en_in = 1'b1;
         end
         lo_in = lo_ff >> 1;
         hi_in = hi_ff >> 1;
      end
   end

   always_comb begin
      if (cmd.start) begin
         acc_in = '0;
      end else if (acc_en_ff) begin
         acc_in = acc_ff + rdata_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   assign stat.clear_last = &clr_ff;
   assign stat.load_ok    = 32'(leaf_index) < 32'(LEAF_COUNT);
   assign stat.pos_root   = pos_ff == NODE_W'(1);
   assign stat.lo_lt_hi   = lo_ff < hi_ff;

   assign range_sum = rsp_data_ff;

endmodule

// ----- design/segment_tree_range_sum.sv -----
// A load walks from its leaf up to the root before the next beat is taken. A query raises
// rsp_tvalid once its walk up the tree is done and the result register is free, and takes
// the next beat once its sum has been loaded there. Both walk the tree one level per pair of
// states (ST_LOAD_WR then ST_LOAD_ADD, ST_Q_LO then ST_Q_HI), a load through the node memory's
// read and write ports, a query through its read port. Reset is synchronous; afterwards a
// clearing pass zeroes every node memory entry, one entry a cycle, while req_tready stays low.
`include "segment_tree_range_sum_defines.svh"

module segment_tree_range_sum #(
   parameter int LEAF_COUNT = strs_pkg::LEAF_COUNT_DEFAULT,
   parameter int VALUE_BITS = strs_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // leaf_index, leaf_value, range_left, range_right, zero pad.
   input  logic [strs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode.
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // range_sum, zero pad.
   output logic [strs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import strs_pkg::*;

   cmd_type          cmd;
   stat_type         stat;
   logic [SUM_W-1:0] range_sum;
   logic             query_beat;

   strs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   strs_dpath #(
      .LEAF_COUNT (LEAF_COUNT),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .leaf_index  (req_tdata[LEAF_INDEX_LSB +: IDX_W]),
      .leaf_value  (req_tdata[LEAF_VALUE_LSB +: VAL_W]),
      .range_left  (req_tdata[RANGE_LEFT_LSB +: IDX_W]),
      .range_right (req_tdata[RANGE_RIGHT_LSB +: IDX_W]),
      .range_sum   (range_sum)
   );

   assign rsp_tdata = RSP_TDATA_W'(range_sum);

   assign query_beat = req_tvalid && req_tready && req_tuser == MODE_QUERY;

   `STRS_ASSERT_NOW(a_no_beat_in_clear, cmd.clear_step, !req_tready, "beat taken during clear")
   `STRS_ASSERT_NOW(a_rsp_slot_free, cmd.rsp_load, !rsp_tvalid || rsp_tready, "result overrun")
   `STRS_ASSERT_NEXT(a_query_busy, query_beat, !req_tready, "ready during query")

endmodule

// ----- verif/segment_tree_range_sum_check.sv -----
`timescale 1ns / 100ps

module segment_tree_range_sum_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [strs_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]                       req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [strs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               mismatch_count,
   output int                               outstanding
);
   import strs_pkg::*;

   localparam int LEAVES = LEAF_COUNT_DEFAULT;

   logic [VAL_W-1:0] leaf_values [LEAVES];
   logic [SUM_W-1:0] pending_sums [$];
   int errors = 0;

   function automatic logic [SUM_W-1:0] range_total(input int unsigned first,
                                                     input int unsigned last);
      logic [63:0] acc;
      int unsigned stop;
      acc = '0;
      stop = (last >= LEAVES) ? LEAVES - 1 : last;
      if (first > stop) return '0;
      for (int unsigned k = first; k <= stop; k++)
         acc = acc + {{(64 - VAL_W){leaf_values[k][VAL_W-1]}}, leaf_values[k]};
      return acc[SUM_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      mode_type mode;
      logic [IDX_W-1:0] idx;
      logic [SUM_W-1:0] want;
      logic [SUM_W-1:0] got;
      if (reset) begin
         foreach (leaf_values[k]) leaf_values[k] = '0;
         pending_sums.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[SUM_W-1:0];
            if (pending_sums.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result beat: range_sum %0d", $signed(got));
               errors++;
            end else begin
               want = pending_sums.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display("range_sum mismatch: expected %0d, got %0d",
                              $signed(want), $signed(got));
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            mode = mode_type'(req_tuser[0]);
            idx = req_tdata[LEAF_INDEX_LSB +: IDX_W];
            if (mode == MODE_QUERY) begin
               pending_sums.push_back(range_total(req_tdata[RANGE_LEFT_LSB +: IDX_W],
                                                  req_tdata[RANGE_RIGHT_LSB +: IDX_W]));
            end else if (int'(idx) < LEAVES) begin
               leaf_values[idx] = req_tdata[LEAF_VALUE_LSB +: VAL_W];
            end
         end
      end
      mismatch_count <= errors;
      outstanding <= pending_sums.size();
   end

endmodule

// ----- verif/segment_tree_range_sum_test.sv -----
`timescale 1ns / 100ps

module segment_tree_range_sum_test;
   import strs_pkg::*;

   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [VAL_W-1:0] VALUE_MAX = 32'h7fff_ffff;
   localparam logic [VAL_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [IDX_W-1:0] LAST_LEAF = IDX_W'(LEAF_COUNT_DEFAULT - 1);

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int cycle_count = 0;
   int quiet_sends = 0;

   segment_tree_range_sum i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   segment_tree_range_sum_check i_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("segment_tree_range_sum_test: FAIL");
         $finish;
      end
   end

   function automatic logic [IDX_W-1:0] pick_leaf();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return IDX_W'(1);
         2: return IDX_W'(LEAF_COUNT_DEFAULT / 2 - 1);
         3: return IDX_W'(LEAF_COUNT_DEFAULT / 2);
         4: return LAST_LEAF;
         default: return IDX_W'($urandom_range(0, LEAF_COUNT_DEFAULT - 1));
      endcase
   endfunction

   task automatic send_item(input mode_type mode, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] lo,
                            input logic [IDX_W-1:0] hi);
      int gap;
      bit taken;
      if (quiet_sends > 0) begin
         quiet_sends--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 31) == 0) quiet_sends = $urandom_range(16, 48);
         gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {2'b00, hi, lo, val, idx};
      do begin
         @(negedge clock);
         taken = (req_tready === 1'b1);
         @(posedge clock);
      end while (!taken);
   endtask

   // The receiver stalls for a long stretch twice so the block backs up into its input.
   initial begin : receiver
      int gap;
      int quiet;
      int delivered;
      bit taken;
      quiet = 0;
      delivered = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (delivered == 250 || delivered == 600) begin
            gap = 600;
         end else if (quiet > 0) begin
            quiet--;
            gap = 0;
         end else begin
            if ($urandom_range(0, 31) == 0) quiet = $urandom_range(16, 48);
            gap = $urandom_range(0, 6);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            taken = (rsp_tvalid === 1'b1);
            @(posedge clock);
         end while (!taken);
         delivered++;
      end
   end

   initial begin : stimulus
      mode_type mode;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
      logic [IDX_W-1:0] swap;
      logic [VAL_W-1:0] val;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_QUERY, '0, '0, '0, LAST_LEAF);
      send_item(MODE_QUERY, '1, '1, '0, '0);
      send_item(MODE_QUERY, '0, '0, IDX_W'(7), IDX_W'(3));
      send_item(MODE_LOAD, '0, VALUE_MAX, '1, '1);
      send_item(MODE_LOAD, LAST_LEAF, VALUE_MIN, '0, '0);
      send_item(MODE_LOAD, IDX_W'(512), '1, '0, '1);
      send_item(MODE_LOAD, IDX_W'(511), VAL_W'(1), '1, '0);
      send_item(MODE_QUERY, '0, '0, '0, LAST_LEAF);
      send_item(MODE_QUERY, '0, '0, '0, '0);
      send_item(MODE_QUERY, '0, '0, LAST_LEAF, LAST_LEAF);
      send_item(MODE_QUERY, '1, '1, IDX_W'(1), IDX_W'(1022));
      send_item(MODE_QUERY, '0, '0, IDX_W'(511), IDX_W'(512));
      send_item(MODE_QUERY, '0, '0, LAST_LEAF, '0);
      send_item(MODE_QUERY, '0, '0, IDX_W'(512), IDX_W'(511));
      send_item(MODE_LOAD, '0, '0, '0, '0);
      send_item(MODE_LOAD, IDX_W'(1), VALUE_MAX, '0, '0);
      send_item(MODE_QUERY, '0, '0, '0, IDX_W'(1));
      send_item(MODE_LOAD, LAST_LEAF, VALUE_MAX, '0, '0);
      send_item(MODE_LOAD, IDX_W'(2), VALUE_MIN, '0, '0);
      send_item(MODE_QUERY, '0, '0, '0, LAST_LEAF);
      send_item(MODE_QUERY, '0, '0, IDX_W'(2), IDX_W'(1022));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idx = pick_leaf();
         lo = pick_leaf();
         hi = pick_leaf();
         case ($urandom_range(0, 9))
            0: val = VALUE_MAX;
            1: val = VALUE_MIN;
            2: val = '1;
            3: val = '0;
            default: val = $urandom();
         endcase
         case ($urandom_range(0, 7))
            0: begin
               lo = '0;
               hi = LAST_LEAF;
            end
            1: hi = lo;
            2: if (lo > hi) begin
               swap = lo;
               lo = hi;
               hi = swap;
            end
            3: hi = lo + IDX_W'($urandom_range(0, 15));
            default: ;
         endcase
         mode = ($urandom_range(0, 1) == 1) ? MODE_QUERY : MODE_LOAD;
         send_item(mode, idx, val, lo, hi);
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("segment_tree_range_sum_test: PASS");
      end else begin
         $display("segment_tree_range_sum_test: FAIL");
      end
      $finish;
   end

endmodule

// ----- segment_tree_range_sum.f -----
+incdir+design
design/strs_pkg.sv
design/strs_ctrl.sv
design/strs_dpath.sv
design/segment_tree_range_sum.sv
verif/segment_tree_range_sum_check.sv
verif/segment_tree_range_sum_test.sv
